@@ sv/mws_pkg.sv @@
// Shared constants for the multiword schoolbook multiplier.
`default_nettype none
package mws_pkg;

  localparam int unsigned MAX_LIMBS_DEF = 32;
  localparam int unsigned LIMB_W        = 64;
  localparam int unsigned HALF_W        = LIMB_W / 2;

  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_MUL    = 2'd2;

endpackage
`default_nettype wire

@@ sv/mws_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module mws_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ sv/mws_mul.sv @@
// Two-stage 64x64 to 128-bit limb multiplier built from 32x32 partial products.
`default_nettype none
module mws_mul
  import mws_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              pp_en,
  input  wire logic              cmb_en,
  input  wire logic [LIMB_W-1:0] a,
  input  wire logic [LIMB_W-1:0] b,
  output logic      [LIMB_W-1:0] lo,
  output logic      [LIMB_W-1:0] hi
);

  logic [LIMB_W-1:0] pp0_r, pp1_r, pp2_r, pp3_r;
  logic [HALF_W+1:0] mid;
  logic [LIMB_W-1:0] hi_nxt;
  logic [LIMB_W-1:0] lo_nxt;

  always_ff @(posedge clk) begin
    if (pp_en) begin
      pp0_r <= LIMB_W'(a[HALF_W-1:0])      * LIMB_W'(b[HALF_W-1:0]);
      pp1_r <= LIMB_W'(a[HALF_W-1:0])      * LIMB_W'(b[LIMB_W-1:HALF_W]);
      pp2_r <= LIMB_W'(a[LIMB_W-1:HALF_W]) * LIMB_W'(b[HALF_W-1:0]);
      pp3_r <= LIMB_W'(a[LIMB_W-1:HALF_W]) * LIMB_W'(b[LIMB_W-1:HALF_W]);
    end
  end

  assign mid = (HALF_W+2)'(pp0_r[LIMB_W-1:HALF_W]) + (HALF_W+2)'(pp1_r[HALF_W-1:0])
             + (HALF_W+2)'(pp2_r[HALF_W-1:0]);
  assign lo_nxt = {mid[HALF_W-1:0], pp0_r[HALF_W-1:0]};
  assign hi_nxt = pp3_r + LIMB_W'(pp1_r[LIMB_W-1:HALF_W]) + LIMB_W'(pp2_r[LIMB_W-1:HALF_W])
                + LIMB_W'(mid[HALF_W+1:HALF_W]);

  always_ff @(posedge clk) begin
    if (cmb_en) begin
      lo <= lo_nxt;
      hi <= hi_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/multiword_schoolbook_multiplier.sv @@
// Sequence: a load is written into its operand store when accepted; a multiply runs
//   a multiply-accumulate pass over every a limb for each b limb, trims zero top limbs
//   one at a time, then emits the limbs in order, holding each through output stalls.
// Throughput: one item at a time, set by the single product-store read-modify-write
//   loop around the shared limb multiplier.
// Reset: clears control and output valid; operand and product stores are not cleared.
`default_nettype none
module multiword_schoolbook_multiplier
  import mws_pkg::*;
#(
  parameter int unsigned MAX_LIMBS = MAX_LIMBS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [4:0]        in_limb_index,
  input  wire logic [LIMB_W-1:0] in_limb_value,
  input  wire logic [5:0]        in_a_length,
  input  wire logic [5:0]        in_b_length,
  input  wire logic              in_a_negative,
  input  wire logic              in_b_negative,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [LIMB_W-1:0] out_product_limb,
  output logic      [5:0]        out_product_index,
  output logic      [6:0]        out_product_length,
  output logic                   out_product_negative,
  output logic                   out_last_limb
);

  localparam int unsigned AW   = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam int unsigned PD   = 2 * MAX_LIMBS;
  localparam int unsigned PW   = $clog2(PD);
  localparam int unsigned LW   = $clog2(MAX_LIMBS + 1);
  localparam int unsigned LENW = $clog2(PD + 1);
  localparam logic [5:0]  MAX6 = 6'(MAX_LIMBS);

  typedef enum logic [3:0] {
    S_IDLE, S_BRD, S_ARD, S_MUL, S_CMB, S_ACC, S_REND,
    S_TRD, S_TCHK, S_ERD, S_EOUT, S_ZERO
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0]     i_r, i_nxt, j_r, j_nxt;
  logic [LW-1:0]     al_r, al_nxt, bl_r, bl_nxt;
  logic [LENW-1:0]   len_r, len_nxt;
  logic [PW-1:0]     k_r, k_nxt;
  logic              neg_r, neg_nxt;
  logic [LIMB_W-1:0] carry_r, carry_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LIMB_W-1:0] out_limb_r, out_limb_nxt;
  logic [5:0]        out_index_r, out_index_nxt;
  logic [6:0]        out_length_r, out_length_nxt;
  logic              out_neg_r, out_neg_nxt;
  logic              out_last_r, out_last_nxt;

  logic              a_we, b_we, p_we, a_re, b_re, p_re;
  logic [AW-1:0]     ld_addr;
  logic [PW-1:0]     p_waddr, p_raddr;
  logic [LIMB_W-1:0] p_wdata;
  logic [LIMB_W-1:0] a_rdata, b_rdata, p_rdata;
  logic [LIMB_W-1:0] mul_lo, mul_hi, p_add;
  logic [LIMB_W+1:0] acc_sum;
  logic              in_xfer, ld_ok, out_free, row_last, col_last, emit_last;
  logic [LW-1:0]     a_len_clamp, b_len_clamp;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign ld_ok     = ({1'b0, in_limb_index} < MAX6);
  assign ld_addr   = AW'(in_limb_index);
  assign out_free  = !out_valid_r || out_ready;
  assign a_len_clamp = (in_a_length > MAX6) ? LW'(MAX_LIMBS) : LW'(in_a_length);
  assign b_len_clamp = (in_b_length > MAX6) ? LW'(MAX_LIMBS) : LW'(in_b_length);
  assign row_last  = (LW'(i_r) + LW'(1)) == al_r;
  assign col_last  = (LW'(j_r) + LW'(1)) == bl_r;
  assign emit_last = (LENW'(k_r) + LENW'(1)) == len_r;

  assign a_we = in_xfer && (in_req_type == REQ_LOAD_A) && ld_ok;
  assign b_we = in_xfer && (in_req_type == REQ_LOAD_B) && ld_ok;
  assign a_re = (state_r == S_ARD);
  assign b_re = (state_r == S_BRD);
  assign p_re = (state_r == S_ARD) || (state_r == S_TRD) || (state_r == S_ERD);

  assign p_add   = (j_r == '0) ? '0 : p_rdata;
  assign acc_sum = (LIMB_W+2)'(mul_lo) + (LIMB_W+2)'(p_add) + (LIMB_W+2)'(carry_r);

  always_comb begin
    p_raddr = PW'(i_r) + PW'(j_r);
    case (state_r)
      S_TRD:   p_raddr = PW'(len_r - LENW'(1));
      S_ERD:   p_raddr = k_r;
      default: p_raddr = PW'(i_r) + PW'(j_r);
    endcase
  end

  always_comb begin
    p_we    = 1'b0;
    p_waddr = PW'(i_r) + PW'(j_r);
    p_wdata = acc_sum[LIMB_W-1:0];
    case (state_r)
      S_ACC: begin
        p_we = 1'b1;
      end
      S_REND: begin
        p_we    = 1'b1;
        p_waddr = PW'(j_r) + PW'(al_r);
        p_wdata = carry_r;
      end
      default: begin
        p_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    al_nxt         = al_r;
    bl_nxt         = bl_r;
    len_nxt        = len_r;
    k_nxt          = k_r;
    neg_nxt        = neg_r;
    carry_nxt      = carry_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_limb_nxt   = out_limb_r;
    out_index_nxt  = out_index_r;
    out_length_nxt = out_length_r;
    out_neg_nxt    = out_neg_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_IDLE: begin
        i_nxt     = '0;
        j_nxt     = '0;
        carry_nxt = '0;
        if (in_xfer && (in_req_type == REQ_MUL)) begin
          al_nxt  = a_len_clamp;
          bl_nxt  = b_len_clamp;
          neg_nxt = in_a_negative ^ in_b_negative;
          if ((a_len_clamp == '0) || (b_len_clamp == '0)) begin
            state_nxt = S_ZERO;
          end else begin
            state_nxt = S_BRD;
          end
        end
      end
      S_BRD: begin
        state_nxt = S_ARD;
      end
      S_ARD: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_CMB;
      end
      S_CMB: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        carry_nxt = mul_hi + LIMB_W'(acc_sum[LIMB_W+1:LIMB_W]);
        if (row_last) begin
          state_nxt = S_REND;
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = S_ARD;
        end
      end
      S_REND: begin
        carry_nxt = '0;
        i_nxt     = '0;
        if (col_last) begin
          len_nxt   = LENW'(al_r) + LENW'(bl_r);
          state_nxt = S_TRD;
        end else begin
          j_nxt     = j_r + AW'(1);
          state_nxt = S_BRD;
        end
      end
      S_TRD: begin
        state_nxt = S_TCHK;
      end
      S_TCHK: begin
        if (p_rdata == '0) begin
          len_nxt = len_r - LENW'(1);
          if (len_r == LENW'(1)) begin
            state_nxt = S_ZERO;
          end else begin
            state_nxt = S_TRD;
          end
        end else begin
          k_nxt     = '0;
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_limb_nxt   = p_rdata;
          out_index_nxt  = 6'(k_r);
          out_length_nxt = 7'(len_r);
          out_neg_nxt    = neg_r;
          out_last_nxt   = emit_last;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + PW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      S_ZERO: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_limb_nxt   = '0;
          out_index_nxt  = '0;
          out_length_nxt = '0;
          out_neg_nxt    = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    al_r         <= al_nxt;
    bl_r         <= bl_nxt;
    len_r        <= len_nxt;
    k_r          <= k_nxt;
    neg_r        <= neg_nxt;
    carry_r      <= carry_nxt;
    out_limb_r   <= out_limb_nxt;
    out_index_r  <= out_index_nxt;
    out_length_r <= out_length_nxt;
    out_neg_r    <= out_neg_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_product_limb     = out_limb_r;
  assign out_product_index    = out_index_r;
  assign out_product_length   = out_length_r;
  assign out_product_negative = out_neg_r;
  assign out_last_limb        = out_last_r;

  mws_ram #(.WIDTH(LIMB_W), .DEPTH(MAX_LIMBS)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (ld_addr),
    .wdata (in_limb_value),
    .re    (a_re),
    .raddr (i_r),
    .rdata (a_rdata)
  );

  mws_ram #(.WIDTH(LIMB_W), .DEPTH(MAX_LIMBS)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (ld_addr),
    .wdata (in_limb_value),
    .re    (b_re),
    .raddr (j_r),
    .rdata (b_rdata)
  );

  mws_ram #(.WIDTH(LIMB_W), .DEPTH(PD)) u_p_store (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  mws_mul u_mul (
    .clk    (clk),
    .pp_en  (state_r == S_MUL),
    .cmb_en (state_r == S_CMB),
    .a      (a_rdata),
    .b      (b_rdata),
    .lo     (mul_lo),
    .hi     (mul_hi)
  );

endmodule
`default_nettype wire

@@ sv/mws_checker.sv @@
// Port-level checker for the multiword schoolbook multiplier, bound to the top level.
`default_nettype none
module mws_checker
  import mws_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [LIMB_W-1:0] out_product_limb,
  input wire logic [5:0]        out_product_index,
  input wire logic [6:0]        out_product_length,
  input wire logic              out_product_negative,
  input wire logic              out_last_limb
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_product_limb)
      && $stable(out_product_index) && $stable(out_last_limb))
    else $error("result changed while stalled");

  a_zero_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_product_length == 7'd0) |->
      out_last_limb && !out_product_negative && (out_product_limb == '0)
      && (out_product_index == 6'd0))
    else $error("zero product result malformed");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_limb && (out_product_length != 7'd0) |->
      ({1'b0, out_product_index} + 7'd1 == out_product_length)
      && (out_product_limb != '0))
    else $error("last limb position or value wrong");

  a_mid_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_limb |->
      ({1'b0, out_product_index} + 7'd1 < out_product_length))
    else $error("non-final limb beyond product length");

endmodule

bind multiword_schoolbook_multiplier mws_checker u_mws_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_product_limb     (out_product_limb),
  .out_product_index    (out_product_index),
  .out_product_length   (out_product_length),
  .out_product_negative (out_product_negative),
  .out_last_limb        (out_last_limb)
);
`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for the multiword schoolbook multiplier: directed corner cases, then random traffic.
module tb;
  import mws_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [LIMB_W-1:0] limb;
    logic [5:0]        pos;
    logic [6:0]        count;
    logic              neg;
    logic              last;
  } product_limb_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_req_type = '0;
  logic [4:0]        in_limb_index = '0;
  logic [LIMB_W-1:0] in_limb_value = '0;
  logic [5:0]        in_a_length = '0;
  logic [5:0]        in_b_length = '0;
  logic              in_a_negative = 1'b0;
  logic              in_b_negative = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [LIMB_W-1:0] out_product_limb;
  logic [5:0]        out_product_index;
  logic [6:0]        out_product_length;
  logic              out_product_negative;
  logic              out_last_limb;

  logic [LIMB_W-1:0] a_limbs [MAX_LIMBS_DEF];
  logic [LIMB_W-1:0] b_limbs [MAX_LIMBS_DEF];
  bit                a_written [MAX_LIMBS_DEF];
  bit                b_written [MAX_LIMBS_DEF];
  product_limb_t     expected_limbs [$];
  product_limb_t     want;
  int                errors = 0;
  int                items_sent = 0;
  int                cycle_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;

  multiword_schoolbook_multiplier dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_limb_index       (in_limb_index),
    .in_limb_value       (in_limb_value),
    .in_a_length         (in_a_length),
    .in_b_length         (in_b_length),
    .in_a_negative       (in_a_negative),
    .in_b_negative       (in_b_negative),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_product_limb    (out_product_limb),
    .out_product_index   (out_product_index),
    .out_product_length  (out_product_length),
    .out_product_negative(out_product_negative),
    .out_last_limb       (out_last_limb)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_limbs.size() == 0) begin
        $display("%0t: unexpected product limb %h index %0d", $time, out_product_limb,
                 out_product_index);
        errors++;
      end else begin
        want = expected_limbs.pop_front();
        if (out_product_limb !== want.limb) begin
          $display("%0t: product_limb expected %h actual %h", $time, want.limb,
                   out_product_limb);
          errors++;
        end
        if (out_product_index !== want.pos) begin
          $display("%0t: product_index expected %0d actual %0d", $time, want.pos,
                   out_product_index);
          errors++;
        end
        if (out_product_length !== want.count) begin
          $display("%0t: product_length expected %0d actual %0d", $time, want.count,
                   out_product_length);
          errors++;
        end
        if (out_product_negative !== want.neg) begin
          $display("%0t: product_negative expected %b actual %b", $time, want.neg,
                   out_product_negative);
          errors++;
        end
        if (out_last_limb !== want.last) begin
          $display("%0t: last_limb expected %b actual %b", $time, want.last, out_last_limb);
          errors++;
        end
      end
    end
  end

  task automatic predict_product(input logic [5:0] a_len, input logic [5:0] b_len,
                                 input logic a_neg, input logic b_neg);
    int                al, bl, n, i, j;
    logic [LIMB_W-1:0] acc [2*MAX_LIMBS_DEF];
    logic [LIMB_W-1:0] carry;
    logic [2*LIMB_W-1:0] t;
    product_limb_t     r;
    al = (a_len > MAX_LIMBS_DEF) ? MAX_LIMBS_DEF : a_len;
    bl = (b_len > MAX_LIMBS_DEF) ? MAX_LIMBS_DEF : b_len;
    n = 0;
    if (al != 0 && bl != 0) begin
      for (i = 0; i < 2 * MAX_LIMBS_DEF; i++) acc[i] = '0;
      for (j = 0; j < bl; j++) begin
        carry = '0;
        for (i = 0; i < al; i++) begin
          t = 128'(a_limbs[i]) * 128'(b_limbs[j]) + 128'(acc[i+j]) + 128'(carry);
          acc[i+j] = t[LIMB_W-1:0];
          carry = t[2*LIMB_W-1:LIMB_W];
        end
        acc[j+al] = carry;
      end
      n = al + bl;
      while (n > 0 && acc[n-1] == '0) n--;
    end
    if (n == 0) begin
      r = '{limb: '0, pos: '0, count: '0, neg: 1'b0, last: 1'b1};
      expected_limbs.push_back(r);
    end else begin
      for (i = 0; i < n; i++) begin
        r = '{limb: acc[i], pos: 6'(i), count: 7'(n), neg: a_neg ^ b_neg,
              last: (i == n - 1)};
        expected_limbs.push_back(r);
      end
    end
  endtask

  task automatic transfer_item(input logic [1:0] req, input logic [4:0] idx,
                               input logic [LIMB_W-1:0] val, input logic [5:0] a_len,
                               input logic [5:0] b_len, input logic a_neg, input logic b_neg);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_limb_index <= idx;
    in_limb_value <= val;
    in_a_length   <= a_len;
    in_b_length   <= b_len;
    in_a_negative <= a_neg;
    in_b_negative <= b_neg;
    do @(posedge clk); while (!in_ready);
    case (req)
      REQ_LOAD_A: a_limbs[idx] = val;
      REQ_LOAD_B: b_limbs[idx] = val;
      REQ_MUL:    predict_product(a_len, b_len, a_neg, b_neg);
      default: ;
    endcase
    if (req != REQ_UNUSED) items_sent++;
  endtask

  task automatic load_limb(input bit side_b, input int idx, input logic [LIMB_W-1:0] val);
    transfer_item(side_b ? REQ_LOAD_B : REQ_LOAD_A, 5'(idx), val, 6'($urandom),
                  6'($urandom), 1'($urandom), 1'($urandom));
    if (side_b) b_written[idx] = 1'b1;
    else a_written[idx] = 1'b1;
  endtask

  task automatic request_product(input logic [5:0] a_len, input logic [5:0] b_len,
                                 input logic a_neg, input logic b_neg);
    transfer_item(REQ_MUL, 5'($urandom), {$urandom, $urandom}, a_len, b_len, a_neg, b_neg);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_limbs.size() != 0);
  endtask

  function automatic logic [LIMB_W-1:0] rand_limb();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(15));
      3: return {1'b1, 63'b0};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [5:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 6'd0;
    if (r < 88) return 6'($urandom_range(4, 1));
    if (r < 96) return 6'($urandom_range(12, 5));
    if (r < 99) return 6'($urandom_range(32, 13));
    return 6'($urandom_range(63, 33));
  endfunction

  function automatic int written_prefix(input bit side_b);
    int n;
    n = 0;
    while (n < MAX_LIMBS_DEF && (side_b ? b_written[n] : a_written[n])) n++;
    return n;
  endfunction

  task automatic test_zero_lengths();
    request_product(6'd0, 6'd5, 1'b1, 1'b0);
    request_product(6'd63, 6'd0, 1'b1, 1'b1);
    request_product(6'd0, 6'd0, 1'b1, 1'b1);
    request_product(6'd0, 6'd32, 1'b0, 1'b1);
  endtask

  task automatic test_unused_request();
    transfer_item(REQ_UNUSED, 5'd31, '1, 6'd63, 6'd63, 1'b1, 1'b1);
    transfer_item(REQ_UNUSED, 5'd0, '0, 6'd2, 6'd2, 1'b0, 1'b0);
  endtask

  task automatic test_full_carry();
    load_limb(1'b0, 0, '1);
    load_limb(1'b0, 1, '1);
    load_limb(1'b1, 0, '1);
    load_limb(1'b1, 1, '1);
    request_product(6'd2, 6'd2, 1'b1, 1'b0);
    request_product(6'd2, 6'd2, 1'b1, 1'b1);
    request_product(6'd1, 6'd2, 1'b0, 1'b1);
  endtask

  task automatic test_zero_product();
    load_limb(1'b0, 0, '0);
    request_product(6'd1, 6'd2, 1'b1, 1'b0);
  endtask

  task automatic test_trimming();
    load_limb(1'b0, 0, 64'd1);
    load_limb(1'b0, 1, '0);
    request_product(6'd2, 6'd1, 1'b0, 1'b1);
  endtask

  task automatic test_top_limb();
    load_limb(1'b0, 31, {1'b1, 63'b0});
    load_limb(1'b1, 31, '1);
  endtask

  task automatic test_length_saturation();
    int i;
    for (i = 0; i < MAX_LIMBS_DEF; i++) begin
      if (!a_written[i]) load_limb(1'b0, i, rand_limb());
      if (!b_written[i]) load_limb(1'b1, i, rand_limb());
    end
    request_product(6'd63, 6'd63, 1'b1, 1'b1);
    request_product(6'd33, 6'd1, 1'b0, 1'b1);
    request_product(6'd32, 6'd40, 1'b1, 1'b0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
    int         stop_at, kind, al, bl, refresh, i;
    logic [5:0] a_len, b_len;
    bit         zero_a;
    wait_for_results();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        a_len = pick_length();
        b_len = pick_length();
        al = (a_len > MAX_LIMBS_DEF) ? MAX_LIMBS_DEF : a_len;
        bl = (b_len > MAX_LIMBS_DEF) ? MAX_LIMBS_DEF : b_len;
        refresh = (al + bl > 12) ? 10 : 100;
        zero_a = ($urandom_range(11) == 0);
        for (i = 0; i < al; i++)
          if (!a_written[i] || $urandom_range(99) < refresh)
            load_limb(1'b0, i, zero_a ? '0 : rand_limb());
        for (i = 0; i < bl; i++)
          if (!b_written[i] || $urandom_range(99) < refresh)
            load_limb(1'b1, i, rand_limb());
        if ($urandom_range(19) == 0) wait_for_results();
        request_product(a_len, b_len, 1'($urandom), 1'($urandom));
      end else if (kind < 80) begin
        load_limb(1'($urandom), $urandom_range(31), rand_limb());
      end else if (kind < 86) begin
        transfer_item(REQ_UNUSED, 5'($urandom), rand_limb(), 6'($urandom), 6'($urandom),
                      1'($urandom), 1'($urandom));
      end else if (kind < 93) begin
        al = written_prefix(1'b0);
        bl = written_prefix(1'b1);
        request_product(6'($urandom_range(al < 6 ? al : 6)),
                        6'($urandom_range(bl < 6 ? bl : 6)), 1'($urandom), 1'($urandom));
      end else begin
        load_limb(1'b0, 0, rand_limb());
        if ($urandom_range(1)) request_product(6'd0, pick_length(), 1'($urandom), 1'b1);
        else request_product(pick_length(), 6'd0, 1'b1, 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_lengths();
    test_unused_request();
    test_full_carry();
    test_zero_product();
    test_trimming();
    test_top_limb();
    test_length_saturation();
    test_random_traffic(0, 0, 90);
    test_random_traffic(55, 0, 90);
    test_random_traffic(0, 55, 90);
    test_random_traffic(36, 36, 90);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_limbs.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/mws_pkg.sv
sv/mws_ram.sv
sv/mws_mul.sv
sv/multiword_schoolbook_multiplier.sv
sv/mws_checker.sv
tb/sv/tb.sv
